/* rtl/shv_pkg.sv */
// shared types and constants for the strict http post header validator
// no dependencies
package shv_pkg;

  typedef enum logic [6:0] {
    PH_REQ        = 7'b0000001,
    PH_LINE_START = 7'b0000010,
    PH_NAME       = 7'b0000100,
    PH_COLON_SP   = 7'b0001000,
    PH_VALUE      = 7'b0010000,
    PH_LINE_LF    = 7'b0100000,
    PH_BLANK_LF   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       reject;
    logic       accept;
    logic [9:0] length;
  } verdict_t;

  typedef logic [0:31][7:0] name_t;
  typedef logic [0:63][7:0] req_t;
  typedef logic [0:15][7:0] ctype_t;

  localparam int unsigned REQ_TEXT_LEN = 39;
  localparam req_t REQ_TEXT = {"POST /api/v1/commands/status HTTP/1.1\r\n", 200'h0};
  localparam ctype_t CTYPE_TEXT = "application/json";
  localparam logic [6:0] CTYPE_LEN = 7'd16;

  localparam int unsigned NAME_COUNT = 6;
  localparam name_t KNOWN_NAMES [NAME_COUNT] = '{
    {"host", 224'h0},
    {"content-type", 160'h0},
    {"content-length", 144'h0},
    {8'h78, 8'h2d, 8'h65, 8'h73, 8'h70, 8'h2d, 8'h6d, 8'h61, 8'h6e, 8'h61,
     8'h67, 8'h65, 8'h6d, 8'h65, 8'h6e, 8'h74, 8'h2d, 8'h74, 8'h61, 8'h67, 96'h0},
    {"transfer-encoding", 120'h0},
    {"expect", 208'h0}
  };
  localparam logic [4:0] KNOWN_LEN [NAME_COUNT] = '{5'd4, 5'd12, 5'd14, 5'd20, 5'd17, 5'd6};

  localparam logic [5:0] ID_HOST   = 6'h01;
  localparam logic [5:0] ID_TYPE   = 6'h02;
  localparam logic [5:0] ID_LEN    = 6'h04;
  localparam logic [5:0] ID_TAG    = 6'h08;
  localparam logic [5:0] ID_FORBID = 6'h30;
  localparam logic [5:0] ALL_NAMES = 6'h3f;
  localparam logic [3:0] ALL_REQUIRED = 4'hf;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_name_char(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2d;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

endpackage

/* rtl/shv_parse.sv */
// byte parser: request line, header names and values, required header tracking
// depends on shv_pkg
module shv_parse #(
  parameter int unsigned TAG_BYTES = 32,
  parameter int unsigned REQUEST_LINE_LENGTH = 39,
  parameter int unsigned TAW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                sor,
  input  logic [7:0]          data,
  input  logic [9:0]          max_header_bytes,
  input  logic [9:0]          max_body_bytes,
  output logic                tag_we,
  output logic [TAW-1:0]      tag_waddr,
  output logic [7:0]          tag_wdata,
  output shv_pkg::verdict_t   verdict
);

  localparam logic [6:0] TAG_DIGITS = 7'(2 * TAG_BYTES);
  localparam logic [5:0] RLL = 6'(REQUEST_LINE_LENGTH);

  logic [9:0]       byte_count, byte_count_next, b_count;
  shv_pkg::phase_t  phase, phase_next, b_phase;
  logic [5:0]       req_idx, req_idx_next, b_req_idx;
  logic [5:0]       cand, cand_next, b_cand;
  logic [4:0]       name_pos, name_pos_next, b_name_pos;
  logic [6:0]       value_pos, value_pos_next, b_value_pos;
  logic [3:0]       seen, seen_next, b_seen;
  logic [9:0]       len_acc, len_acc_next, b_len_acc;
  logic [3:0]       high_nib, high_nib_next, b_high_nib;
  logic             err, err_next, b_err;
  logic             given, given_next, b_given;

  logic [7:0]       low;
  logic [5:0]       cand_match;
  logic [5:0]       cand_fresh;
  logic [5:0]       cand_len;
  logic [3:0]       digit;
  logic             digit_ok;
  logic             rej;

  always_comb begin
    if (sor) begin
      b_count = '0; b_phase = shv_pkg::PH_REQ; b_req_idx = '0;
      b_cand = shv_pkg::ALL_NAMES; b_name_pos = '0; b_value_pos = '0;
      b_seen = '0; b_len_acc = '0; b_high_nib = '0; b_err = 1'b0; b_given = 1'b0;
    end else begin
      b_count = byte_count; b_phase = phase; b_req_idx = req_idx;
      b_cand = cand; b_name_pos = name_pos; b_value_pos = value_pos;
      b_seen = seen; b_len_acc = len_acc; b_high_nib = high_nib;
      b_err = err; b_given = given;
    end
  end

  // name matching against the known header names
  always_comb begin
    low = shv_pkg::to_lower(data);
    for (int k = 0; k < shv_pkg::NAME_COUNT; k++) begin
      cand_match[k] = b_cand[k] && !(b_name_pos >= shv_pkg::KNOWN_LEN[k] ||
                      low != shv_pkg::KNOWN_NAMES[k][b_name_pos]);
      cand_fresh[k] = !(low != shv_pkg::KNOWN_NAMES[k][0]);
      cand_len[k]   = b_cand[k] && (shv_pkg::KNOWN_LEN[k] == b_name_pos);
    end
  end

  always_comb begin
    digit_ok = 1'b1;
    digit = '0;
    if (data >= 8'h30 && data <= 8'h39) begin
      digit = data[3:0];
    end else if (data >= 8'h61 && data <= 8'h66) begin
      digit = 4'(data - 8'h57);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    byte_count_next = byte_count; phase_next = phase; req_idx_next = req_idx;
    cand_next = cand; name_pos_next = name_pos; value_pos_next = value_pos;
    seen_next = seen; len_acc_next = len_acc; high_nib_next = high_nib;
    err_next = err; given_next = given;
    tag_we = 1'b0;
    tag_waddr = TAW'(b_value_pos >> 1);
    tag_wdata = {b_high_nib, digit};
    rej = 1'b0;
    verdict = '0;
    if (fire) begin
      byte_count_next = b_count; phase_next = b_phase; req_idx_next = b_req_idx;
      cand_next = b_cand; name_pos_next = b_name_pos; value_pos_next = b_value_pos;
      seen_next = b_seen; len_acc_next = b_len_acc; high_nib_next = b_high_nib;
      err_next = b_err; given_next = b_given;
      if (!b_given) begin
        if (b_count >= max_header_bytes) begin
          rej = 1'b1;
        end else begin
          byte_count_next = b_count + 10'd1;
          case (b_phase)
            shv_pkg::PH_REQ: begin
              if (32'(b_req_idx) >= shv_pkg::REQ_TEXT_LEN ||
                  data != shv_pkg::REQ_TEXT[b_req_idx]) begin
                rej = 1'b1;
              end else begin
                req_idx_next = b_req_idx + 6'd1;
                if (req_idx_next >= RLL) phase_next = shv_pkg::PH_LINE_START;
              end
            end
            shv_pkg::PH_LINE_START: begin
              if (data == shv_pkg::CH_CR) begin
                phase_next = shv_pkg::PH_BLANK_LF;
              end else if (!shv_pkg::is_name_char(data)) begin
                rej = 1'b1;
              end else begin
                cand_next = cand_fresh;
                name_pos_next = 5'd1;
                phase_next = shv_pkg::PH_NAME;
              end
            end
            shv_pkg::PH_NAME: begin
              if (shv_pkg::is_name_char(data)) begin
                cand_next = cand_match;
                if (b_name_pos < 5'd31) name_pos_next = b_name_pos + 5'd1;
              end else if (data != shv_pkg::CH_COLON) begin
                rej = 1'b1;
              end else if ((cand_len & shv_pkg::ID_FORBID) != '0 ||
                           (cand_len[3:0] & b_seen) != '0) begin
                rej = 1'b1;
              end else begin
                cand_next = cand_len;
                value_pos_next = '0; len_acc_next = '0; high_nib_next = '0;
                phase_next = shv_pkg::PH_COLON_SP;
              end
            end
            shv_pkg::PH_COLON_SP: begin
              if (data != shv_pkg::CH_SPACE) rej = 1'b1;
              else phase_next = shv_pkg::PH_VALUE;
            end
            shv_pkg::PH_VALUE: begin
              if (data == shv_pkg::CH_CR) begin
                phase_next = shv_pkg::PH_LINE_LF;
              end else if (data < 8'h20 || data > 8'h7e) begin
                rej = 1'b1;
              end else begin
                if (b_cand == shv_pkg::ID_TYPE) begin
                  if (b_value_pos >= shv_pkg::CTYPE_LEN ||
                      data != shv_pkg::CTYPE_TEXT[b_value_pos[3:0]]) rej = 1'b1;
                end else if (b_cand == shv_pkg::ID_LEN) begin
                  if (b_value_pos >= 7'd3 || data < 8'h30 || data > 8'h39) rej = 1'b1;
                  else len_acc_next = (b_len_acc << 3) + (b_len_acc << 1) +
                                      10'(data[3:0]);
                end else if (b_cand == shv_pkg::ID_TAG) begin
                  if (b_value_pos >= TAG_DIGITS || !digit_ok) begin
                    rej = 1'b1;
                  end else if (!b_value_pos[0]) begin
                    high_nib_next = digit;
                  end else begin
                    tag_we = 1'b1;
                  end
                end
                if (b_value_pos < 7'd127) value_pos_next = b_value_pos + 7'd1;
              end
            end
            shv_pkg::PH_LINE_LF: begin
              if (data != shv_pkg::CH_LF) rej = 1'b1;
              else if (b_cand == shv_pkg::ID_HOST && b_value_pos == '0) rej = 1'b1;
              else if (b_cand == shv_pkg::ID_TYPE && b_value_pos != shv_pkg::CTYPE_LEN)
                rej = 1'b1;
              else if (b_cand == shv_pkg::ID_LEN && (b_value_pos == '0 ||
                       b_len_acc == '0 || b_len_acc > max_body_bytes)) rej = 1'b1;
              else if (b_cand == shv_pkg::ID_TAG && b_value_pos != TAG_DIGITS) rej = 1'b1;
              else begin
                seen_next = b_seen | b_cand[3:0];
                phase_next = shv_pkg::PH_LINE_START;
              end
            end
            shv_pkg::PH_BLANK_LF: begin
              if (data != shv_pkg::CH_LF || b_seen != shv_pkg::ALL_REQUIRED) begin
                rej = 1'b1;
              end else begin
                given_next = 1'b1;
                verdict.accept = 1'b1;
                verdict.length = b_len_acc;
              end
            end
            default: rej = 1'b1;
          endcase
        end
        if (rej) begin
          err_next = 1'b1;
          given_next = 1'b1;
          verdict.reject = 1'b1;
          tag_we = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0; phase <= shv_pkg::PH_REQ; req_idx <= '0;
      cand <= shv_pkg::ALL_NAMES; name_pos <= '0; value_pos <= '0;
      seen <= '0; len_acc <= '0; high_nib <= '0; err <= 1'b0; given <= 1'b0;
    end else begin
      byte_count <= byte_count_next; phase <= phase_next; req_idx <= req_idx_next;
      cand <= cand_next; name_pos <= name_pos_next; value_pos <= value_pos_next;
      seen <= seen_next; len_acc <= len_acc_next; high_nib <= high_nib_next;
      err <= err_next; given <= given_next;
    end
  end

endmodule

/* rtl/strict_http_post_header_validator_top.sv */
// top level: config registers, tag memory, verdict readout and output register
// depends on shv_pkg and shv_parse
// one byte accepted per cycle while parsing; a reject result is registered in the readout
// stage, then in the output register; an accept streams TAG_BYTES results from tag memory,
// one per cycle unless the output stalls; input is stalled during that readout (registered
// memory read port) and while a result waits in the readout stage behind a stalled output
// synchronous reset clears control state and loads max_header_bytes 512, max_body_bytes 384
module strict_http_post_header_validator_top #(
  parameter int unsigned TAG_BYTES = 32,
  parameter int unsigned REQUEST_LINE_LENGTH = 39
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       start_of_request,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic [9:0] content_len,
  output logic [4:0] tag_index,
  output logic [7:0] tag_byte,
  output logic       last
);

  localparam int unsigned TAW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam logic [TAW-1:0] LAST_IDX = TAW'(TAG_BYTES - 1);

  logic [9:0] max_header_bytes, max_body_bytes;

  logic               in_fire;
  logic               tag_we;
  logic [TAW-1:0]     tag_waddr;
  logic [7:0]         tag_wdata;
  shv_pkg::verdict_t  verdict;

  logic [7:0]     tag_mem [TAG_BYTES];
  logic [7:0]     rdata;

  logic           run_active;
  logic [TAW-1:0] run_idx;
  logic [9:0]     run_len;

  logic           s1_valid, s1_acc, s1_last;
  logic [TAW-1:0] s1_idx;
  logic [9:0]     s1_len;

  logic out_free, s1_move, issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_header_bytes <= 10'd512;
      max_body_bytes   <= 10'd384;
    end else if (cfg_we) begin
      if (cfg_index) max_body_bytes <= cfg_data;
      else max_header_bytes <= cfg_data;
    end
  end

  assign in_stall = run_active || (s1_valid && !out_free);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign issue    = run_active && (!s1_valid || s1_move);

  shv_parse #(
    .TAG_BYTES(TAG_BYTES),
    .REQUEST_LINE_LENGTH(REQUEST_LINE_LENGTH),
    .TAW(TAW)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .fire(in_fire),
    .sor(start_of_request),
    .data(data_byte),
    .max_header_bytes(max_header_bytes),
    .max_body_bytes(max_body_bytes),
    .tag_we(tag_we),
    .tag_waddr(tag_waddr),
    .tag_wdata(tag_wdata),
    .verdict(verdict)
  );

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (issue) rdata <= tag_mem[run_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_idx    <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (in_fire && verdict.accept) begin
        run_active <= 1'b1;
        run_idx    <= '0;
      end else if (issue) begin
        if (run_idx == LAST_IDX) run_active <= 1'b0;
        else run_idx <= run_idx + 1'b1;
      end
      if (issue || (in_fire && verdict.reject)) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && verdict.accept) run_len <= verdict.length;
    if (issue) begin
      s1_acc  <= 1'b1;
      s1_idx  <= run_idx;
      s1_len  <= run_len;
      s1_last <= (run_idx == LAST_IDX);
    end else if (in_fire && verdict.reject) begin
      s1_acc  <= 1'b0;
      s1_idx  <= '0;
      s1_len  <= '0;
      s1_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      accepted    <= s1_acc;
      content_len <= s1_acc ? s1_len : 10'd0;
      tag_index   <= s1_acc ? 5'(s1_idx) : 5'd0;
      tag_byte    <= s1_acc ? rdata : 8'd0;
      last        <= s1_last;
    end
  end

endmodule

/* rtl/shv_check.sv */
// port level checks for the header validator, bound to the top level
// depends on strict_http_post_header_validator_top
module shv_check #(
  parameter int unsigned TAG_BYTES = 32
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accepted,
  input logic [9:0] content_len,
  input logic [4:0] tag_index,
  input logic [7:0] tag_byte,
  input logic       last
);

  logic out_fire;
  assign out_fire = out_valid && !out_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({accepted, content_len, tag_index, tag_byte, last}))
    else $error("output transaction changed while stalled");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_fire && !accepted |-> last && content_len == 10'd0 && tag_byte == 8'd0)
    else $error("reject result not a single zero transaction");

  a_accept_last: assert property (@(posedge clk) disable iff (rst)
    out_fire && accepted |-> (last == (tag_index == 5'(TAG_BYTES - 1))))
    else $error("last flag out of place in accept run");

endmodule

bind strict_http_post_header_validator_top shv_check #(.TAG_BYTES(TAG_BYTES)) u_check (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .accepted(accepted),
  .content_len(content_len),
  .tag_index(tag_index),
  .tag_byte(tag_byte),
  .last(last)
);
